// ----- hdl/eild_pkg.sv -----
// Package for the edge interrupt lockout detector.
// Widths, register indexes, hook mode codes and the edge re-arm function.
// No dependencies.
package eild_pkg;

    localparam int PIN_W         = 8;
    localparam int TIME_W        = 32;
    localparam int LOCK_W        = 16;
    localparam int FIRED_W       = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int MASK_HOOKS    = 4;   // hooks that have a mask and mode register
    localparam int HOOK_COUNT_DEF = 4;

    localparam logic [LOCK_W-1:0] LOCKOUT_RESET = 16'd100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOOK0_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOOK1_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOOK2_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOOK3_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOOK_MODES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT    = 3'd5;

    typedef enum logic [1:0] {
        MODE_KEEP    = 2'd0,
        MODE_RISING  = 2'd1,
        MODE_FALLING = 2'd2,
        MODE_BOTH    = 2'd3
    } hook_mode_t;

    // Per-hook control from the datapath to a hook's lockout unit
    typedef struct packed {
        logic hit;      // a watched pin saw its selected edge
        logic commit;   // beat moves to the result register, armed
    } hook_ctl_t;

    // Re-arm edge selection of the masked pins (0 = rising, 1 = falling)
    function automatic logic [PIN_W-1:0] apply_mode(
        input logic [PIN_W-1:0] sel,
        input logic [PIN_W-1:0] mask,
        input hook_mode_t       mode,
        input logic [PIN_W-1:0] levels
    );
        logic [PIN_W-1:0] res;
        res = sel;
        case (mode)
            MODE_RISING:  res = sel & ~mask;
            MODE_FALLING: res = sel | mask;
            MODE_BOTH:    res = (sel & ~mask) | (levels & mask);
            default:      res = sel;
        endcase
        return res;
    endfunction

endpackage

// ----- hdl/eild_hook.sv -----
// One hook's lockout unit: last-fire timestamp and wrapping elapsed compare.
// Depends on eild_pkg.
module eild_hook (
    input  logic                        clk,
    input  logic                        rst_n,
    input  eild_pkg::hook_ctl_t         ctl,
    input  logic [eild_pkg::TIME_W-1:0] time_now,
    input  logic [eild_pkg::LOCK_W-1:0] lockout,
    output logic                        fire
);
    import eild_pkg::*;

    logic [TIME_W-1:0] last_fire_reg;
    logic [TIME_W-1:0] last_fire_next;
    logic [TIME_W-1:0] elapsed;

    assign elapsed = time_now - last_fire_reg;
    assign fire    = ctl.hit && (elapsed > {{(TIME_W-LOCK_W){1'b0}}, lockout});

    always_comb
    begin
        last_fire_next = last_fire_reg;
        if (ctl.commit && fire)
        begin
            last_fire_next = time_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_fire_reg <= '0;
        end
        else
        begin
            last_fire_reg <= last_fire_next;
        end
    end

`ifndef NO_ASSERTIONS
    // timestamp only moves on a committed firing
    a_ts_moves_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.commit && fire) |=> $stable(last_fire_reg))
        else $error("hook timestamp changed without a firing");
    // a fire needs a hit
    a_fire_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> ctl.hit)
        else $error("hook fired without a hit");
    // after a committed firing, the timestamp equals that beat's time
    a_ts_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit && fire) |=> last_fire_reg == $past(time_now))
        else $error("hook timestamp not loaded on firing");
`endif

endmodule

// ----- hdl/edge_interrupt_lockout_detector.sv -----
// Edge interrupt lockout detector, top level.
// Pipeline: input register, then result register; out_ready low can stall both.
// One beat per cycle while out_ready is high; edge and lockout logic is combinational.
// Reset: asynchronous, active low; clears edge state, timestamps, config to defaults.
// The first sample after reset only arms edge selection and returns zero results.
// Depends on eild_pkg and eild_hook.
module edge_interrupt_lockout_detector #(
    parameter int HOOK_COUNT = eild_pkg::HOOK_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [eild_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [eild_pkg::CFG_DATA_W-1:0]  cfg_data,
    // sample channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [eild_pkg::PIN_W-1:0]       pin_levels,
    input  logic [eild_pkg::TIME_W-1:0]      time_now,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [eild_pkg::FIRED_W-1:0]     fired_hooks,
    output logic [eild_pkg::PIN_W-1:0]       edge_flags
);
    import eild_pkg::*;

    // Hooks past the fourth have no mask and never fire, so they get no hardware.
    localparam int ACTIVE = (HOOK_COUNT < MASK_HOOKS) ? HOOK_COUNT : MASK_HOOKS;

    // ---------------- configuration registers ----------------
    logic [PIN_W-1:0]  hook_mask_reg [MASK_HOOKS];
    logic [PIN_W-1:0]  hook_modes_reg;
    logic [LOCK_W-1:0] lockout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MASK_HOOKS; i++)
            begin
                hook_mask_reg[i] <= '0;
            end
            hook_modes_reg <= '0;
            lockout_reg    <= LOCKOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_HOOK0_MASK: hook_mask_reg[0] <= cfg_data[PIN_W-1:0];
                REG_HOOK1_MASK: hook_mask_reg[1] <= cfg_data[PIN_W-1:0];
                REG_HOOK2_MASK: hook_mask_reg[2] <= cfg_data[PIN_W-1:0];
                REG_HOOK3_MASK: hook_mask_reg[3] <= cfg_data[PIN_W-1:0];
                REG_HOOK_MODES: hook_modes_reg   <= cfg_data[PIN_W-1:0];
                REG_LOCKOUT:    lockout_reg      <= cfg_data[LOCK_W-1:0];
                default:        ;   // writes past the list are dropped
            endcase
        end
    end

    // ---------------- handshake ----------------
    // s1 = input register, result register = output. A beat moves from s1 to
    // the result register when the result register is empty or being drained.
    logic s1_valid_reg, s1_valid_next;
    logic res_valid_reg, res_valid_next;
    logic advance;

    assign advance  = s1_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // input payload register
    logic [PIN_W-1:0]  s1_levels_reg;
    logic [TIME_W-1:0] s1_time_reg;

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_levels_reg <= pin_levels;
            s1_time_reg   <= time_now;
        end
    end

    // ---------------- edge state ----------------
    logic             armed_reg, armed_next;
    logic [PIN_W-1:0] prev_levels_reg, prev_levels_next;
    logic [PIN_W-1:0] edge_sel_reg, edge_sel_next;
    logic [PIN_W-1:0] flags;
    logic [ACTIVE-1:0] fire;

    // rising edges where select is 0, falling where it is 1; nothing while unarmed
    assign flags = armed_reg ?
        ((~prev_levels_reg & s1_levels_reg & ~edge_sel_reg) |
         (prev_levels_reg & ~s1_levels_reg & edge_sel_reg)) : '0;

    // ---------------- per-hook lockout units ----------------
    genvar h;
    generate
        for (h = 0; h < ACTIVE; h++)
        begin : g_hook
            hook_ctl_t ctl;
            assign ctl.hit    = |(flags & hook_mask_reg[h]);
            assign ctl.commit = advance && armed_reg;

            eild_hook u_hook (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .time_now (s1_time_reg),
                .lockout  (lockout_reg),
                .fire     (fire[h])
            );
        end
    endgenerate

    // Re-arm in hook order so a later hook, unless its mode is keep, wins on shared
    // pins. The arming sample applies every hook's mode; afterwards only firing hooks do.
    always_comb
    begin
        edge_sel_next    = edge_sel_reg;
        prev_levels_next = prev_levels_reg;
        armed_next       = armed_reg;
        if (advance)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                if (!armed_reg || fire[i])
                begin
                    edge_sel_next = apply_mode(edge_sel_next, hook_mask_reg[i],
                        hook_mode_t'(hook_modes_reg[2*i +: 2]), s1_levels_reg);
                end
            end
            prev_levels_next = s1_levels_reg;
            armed_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg       <= 1'b0;
            prev_levels_reg <= '0;
            edge_sel_reg    <= '0;
        end
        else
        begin
            armed_reg       <= armed_next;
            prev_levels_reg <= prev_levels_next;
            edge_sel_reg    <= edge_sel_next;
        end
    end

    // ---------------- result register ----------------
    logic [FIRED_W-1:0] fired_reg;
    logic [PIN_W-1:0]   flags_reg;
    logic [FIRED_W-1:0] fired_wide;

    always_comb
    begin
        fired_wide = '0;
        fired_wide[ACTIVE-1:0] = armed_reg ? fire : '0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fired_reg <= fired_wide;
            flags_reg <= flags;
        end
    end

    assign out_valid   = res_valid_reg;
    assign fired_hooks = fired_reg;
    assign edge_flags  = flags_reg;

`ifndef NO_ASSERTIONS
    // a hook can only fire on a sample that flagged some pin
    a_fire_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fired_hooks == '0 || edge_flags != '0))
        else $error("hook fired with no edge flag");
    // once armed, stays armed until reset
    a_armed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |=> armed_reg)
        else $error("armed state dropped");
    // an empty result register never blocks the input side
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");
    // a beat leaving the input register always lands in the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("beat lost between stages");
`endif

endmodule
